// ===== sv/double_buffer_stream_control_unit_defines.svh =====
// assertion macros for the stream control unit
`ifndef DOUBLE_BUFFER_STREAM_CONTROL_UNIT_DEFINES_SVH
`define DOUBLE_BUFFER_STREAM_CONTROL_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define DBSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define DBSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/dbsc_pkg.sv =====
// ---------------------------------------------------------------------------
// dbsc_pkg
// types and constants shared by the stream control unit modules
// ---------------------------------------------------------------------------
`default_nettype none
package dbsc_pkg;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_BUFFER = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [31:0] MAGIC_SWAP  = 32'h7047_4156;
  localparam logic [31:0] MAGIC_PLAIN = 32'h5641_4770;
  localparam logic [15:0] HALF_BASE   = 16'h6000;
  localparam logic [15:0] TRAP_ADDR   = 16'hC000;
  localparam logic [31:0] ADDR_MAX    = 32'h0000_BFFF;
  localparam logic [16:0] POS_START   = 17'd48;
  localparam logic [12:0] CLK_STEP    = 13'h1C00;
  localparam logic [13:0] PITCH_MAX   = 14'h3FFF;
  // rate*4096/48000 = rate*32/375; reciprocal of 375/32 scaled by 2^27,
  // exact for every rate below the saturation point
  localparam logic [31:0] PITCH_RATE_MAX = 32'd191999;
  localparam logic [23:0] PITCH_RECIP    = 24'd11453247;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] voice_addr;
    logic [31:0] header_magic;
    logic [31:0] header_length;
    logic [31:0] header_rate;
    logic        hold_paused;
  } in_item_t;

  typedef struct packed {
    logic        finished;
    logic        bad_header;
    logic        data_request;
    logic        loop_write;
    logic [15:0] loop_addr;
    logic        key_on;
    logic        dest_half;
    logic        loop_flag;
    logic        pitch_write;
    logic [13:0] pitch;
    logic [31:0] play_clock;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic step;      // run the stream logic on the held item
    logic div_start; // start the clock divide
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
  } dp_status_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

// ===== sv/dbsc_divider.sv =====
// ---------------------------------------------------------------------------
// dbsc_divider
// restoring divider, 45-bit dividend by 32-bit divisor, one bit a cycle
// ---------------------------------------------------------------------------
`default_nettype none
module dbsc_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [44:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [44:0]      quotient
);
  logic [32:0] rem;
  logic [5:0]  count;
  logic [33:0] trial;

  assign trial = {rem, quotient[44]} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= 6'd44;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (trial[33]) begin
        rem      <= {rem[31:0], quotient[44]};
        quotient <= {quotient[43:0], 1'b0};
      end else begin
        rem      <= trial[32:0];
        quotient <= {quotient[43:0], 1'b1};
      end
      if (count == 6'd0) begin
        busy <= 1'b0;
      end
      count <= count - 6'd1;
    end
  end
endmodule
`default_nettype wire

// ===== sv/dbsc_datapath.sv =====
// ---------------------------------------------------------------------------
// dbsc_datapath
// stream state, tick and buffer decisions, pitch and clock division
// ---------------------------------------------------------------------------
`default_nettype none
`include "double_buffer_stream_control_unit_defines.svh"
module dbsc_datapath #(
  parameter int HALF_SIZE = 24576
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dbsc_pkg::in_item_t    item,
  input  wire dbsc_pkg::dp_cmd_t     cmd,
  output dbsc_pkg::dp_status_t       status,
  output dbsc_pkg::out_item_t        result
);
  import dbsc_pkg::*;

  localparam logic signed [34:0] HALF_S = 35'(HALF_SIZE);
  localparam logic signed [34:0] LEFT_MIN = -35'sd4294967296;

  logic active, stopped, started, playing, ready_flag, loop_moved;
  logic last_half, end_valid, buffer_parity;
  logic signed [34:0] stop_point;
  logic signed [34:0] bytes_left;
  logic [31:0] stream_rate;
  logic [16:0] play_pos;
  logic [31:0] sample_total;
  logic [1:0]  buffers_seen;

  logic        div_busy;
  logic [44:0] quotient;
  logic [44:0] dividend;
  logic [31:0] divisor;

  // step result fields other than play_clock and pitch
  logic        r_fin, r_bad, r_lw, r_kon, r_half, r_mle, r_pw, r_zero_clk;
  logic [15:0] r_la;

  // next-state logic
  logic active_next, stopped_next, started_next, playing_next, ready_flag_next;
  logic loop_moved_next, last_half_next, end_valid_next, buffer_parity_next;
  logic signed [34:0] stop_point_next, bytes_left_next, left_sub;
  logic [31:0] stream_rate_next, sample_total_next;
  logic [16:0] play_pos_next, pos;
  logic [1:0]  buffers_seen_next;
  logic        fin, bad, lw, kon, half, mle, pw, alive, decided, first_half;
  logic [15:0] la;
  logic [31:0] rate_v, len_v;
  logic signed [34:0] pp;

  always_comb begin
    active_next = active; stopped_next = stopped; started_next = started;
    playing_next = playing; ready_flag_next = ready_flag;
    loop_moved_next = loop_moved; last_half_next = last_half;
    end_valid_next = end_valid; buffer_parity_next = buffer_parity;
    stop_point_next = stop_point; bytes_left_next = bytes_left;
    stream_rate_next = stream_rate; sample_total_next = sample_total;
    play_pos_next = play_pos; buffers_seen_next = buffers_seen;
    fin = 1'b0; bad = 1'b0; lw = 1'b0; kon = 1'b0; half = 1'b0;
    mle = 1'b0; pw = 1'b0; la = '0; alive = 1'b1; decided = 1'b0;
    pos = play_pos; pp = '0; first_half = 1'b0;
    rate_v = item.header_rate; len_v = item.header_length;
    left_sub = '0;
    case (item.command)
      CMD_START: begin
        stopped_next = 1'b0; started_next = 1'b0; loop_moved_next = 1'b0;
        end_valid_next = 1'b0; stop_point_next = '0; bytes_left_next = '0;
        buffers_seen_next = '0; buffer_parity_next = 1'b0;
        playing_next = 1'b0; play_pos_next = POS_START;
        sample_total_next = '0; ready_flag_next = 1'b1; active_next = 1'b1;
      end
      CMD_BUFFER: begin
        if (active && !stopped) begin
          if (buffers_seen == 2'd0) begin
            if (item.header_magic != MAGIC_SWAP && item.header_magic != MAGIC_PLAIN) begin
              stopped_next = 1'b1;
              bad = 1'b1;
            end else begin
              if (item.header_magic == MAGIC_SWAP) begin
                rate_v = swap32(item.header_rate);
                len_v  = swap32(item.header_length);
              end
              stream_rate_next = rate_v;
              last_half_next = 1'b0;
              left_sub = $signed({3'b000, len_v}) + 35'sd48;
              if (HALF_S >= left_sub) begin
                stop_point_next = left_sub - 35'sd16;
                end_valid_next = 1'b1;
              end else if (!end_valid) begin
                lw = 1'b1;
                la = TRAP_ADDR;
              end
              kon = 1'b1;
              started_next = 1'b1;
              bytes_left_next = left_sub - HALF_S;
              buffers_seen_next = 2'd1;
              buffer_parity_next = 1'b1;
            end
          end else begin
            if (HALF_S < bytes_left) begin
              mle = 1'b1;
            end else begin
              stop_point_next = buffer_parity ? bytes_left + 35'sh5FF0
                                              : bytes_left - 35'sd16;
              end_valid_next = 1'b1;
            end
            half = buffer_parity;
            if (buffers_seen == 2'd1) begin
              pw = !item.hold_paused;
              play_pos_next = POS_START;
              playing_next = 1'b1;
            end else begin
              lw = 1'b1;
              la = buffer_parity ? HALF_BASE : 16'h0000;
            end
            ready_flag_next = 1'b0;
            left_sub = bytes_left - HALF_S;
            bytes_left_next = (left_sub < LEFT_MIN) ? LEFT_MIN : left_sub;
            if (buffers_seen < 2'd2) begin
              buffers_seen_next = buffers_seen + 2'd1;
            end
            buffer_parity_next = !buffer_parity;
          end
        end
      end
      CMD_TICK: begin
        if (active) begin
          if (playing) begin
            if (item.voice_addr > ADDR_MAX) begin
              pos = last_half ? {1'b0, TRAP_ADDR} : {1'b0, HALF_BASE};
            end else begin
              pos = item.voice_addr[16:0];
              last_half_next = item.voice_addr[15:0] >= HALF_BASE;
            end
            if (pos >= play_pos) begin
              sample_total_next = sample_total + 32'(pos - play_pos);
            end else begin
              sample_total_next = sample_total + 32'(pos + {1'b0, TRAP_ADDR} - play_pos);
            end
            play_pos_next = pos;
          end
          if (stopped) begin
            alive = 1'b0;
          end else if (started) begin
            if (end_valid) begin
              pp = $signed({18'd0, play_pos_next});
              if ({pp[34:4], 4'd0} == stop_point) begin
                alive = 1'b0;
                decided = 1'b1;
              end else if ((pp < 35'sh6000 && stop_point < 35'sh6000) ||
                           (pp > 35'sh5FFF && stop_point > 35'sh5FFF)) begin
                if (!loop_moved && {15'd0, play_pos_next} < stop_point[31:0]) begin
                  lw = 1'b1;
                  la = stop_point[15:0];
                  loop_moved_next = 1'b1;
                end
                decided = 1'b1;
              end
            end
            if (!decided) begin
              first_half = play_pos_next < {1'b0, HALF_BASE};
              if (first_half == buffer_parity) begin
                ready_flag_next = 1'b1;
                lw = 1'b1;
                la = TRAP_ADDR;
              end
            end
          end
          if (!alive) begin
            playing_next = 1'b0; active_next = 1'b0;
            stopped_next = 1'b0; started_next = 1'b0; ready_flag_next = 1'b0;
            loop_moved_next = 1'b0; end_valid_next = 1'b0; stop_point_next = '0;
            bytes_left_next = '0; buffers_seen_next = '0;
            buffer_parity_next = 1'b0;
            fin = 1'b1; lw = 1'b0; la = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0; stopped <= 1'b0; started <= 1'b0; playing <= 1'b0;
      ready_flag <= 1'b0; loop_moved <= 1'b0; last_half <= 1'b0;
      end_valid <= 1'b0; buffer_parity <= 1'b0; stop_point <= '0;
      bytes_left <= '0; stream_rate <= '0; play_pos <= POS_START;
      sample_total <= '0; buffers_seen <= '0;
      r_fin <= 1'b0; r_bad <= 1'b0; r_lw <= 1'b0; r_la <= '0; r_kon <= 1'b0;
      r_half <= 1'b0; r_mle <= 1'b0; r_pw <= 1'b0; r_zero_clk <= 1'b1;
    end else if (cmd.step) begin
      active <= active_next; stopped <= stopped_next; started <= started_next;
      playing <= playing_next; ready_flag <= ready_flag_next;
      loop_moved <= loop_moved_next; last_half <= last_half_next;
      end_valid <= end_valid_next; buffer_parity <= buffer_parity_next;
      stop_point <= stop_point_next; bytes_left <= bytes_left_next;
      stream_rate <= stream_rate_next; play_pos <= play_pos_next;
      sample_total <= sample_total_next; buffers_seen <= buffers_seen_next;
      r_fin <= fin; r_bad <= bad; r_lw <= lw; r_la <= la; r_kon <= kon;
      r_half <= half; r_mle <= mle; r_pw <= pw;
      r_zero_clk <= (item.command == CMD_NOP) || (stream_rate_next == 32'd0);
    end
  end

  // dividend: 0x1C00*(total/16) over rate
  assign dividend = 45'(CLK_STEP) * 45'(sample_total[31:4]);
  assign divisor  = stream_rate;

  dbsc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // pitch by reciprocal multiply, settled long before the result is shown
  logic [41:0] pitch_prod;
  logic [13:0] pitch_q;
  assign pitch_prod = 42'(stream_rate[17:0]) * 42'(PITCH_RECIP);
  always_ff @(posedge clk) begin
    if (stream_rate > PITCH_RATE_MAX) begin
      pitch_q <= PITCH_MAX;
    end else begin
      pitch_q <= pitch_prod[40:27];
    end
  end

  assign status.div_busy = div_busy;

  always_comb begin
    result.finished      = r_fin;
    result.bad_header    = r_bad;
    result.data_request  = active && !stopped && (buffers_seen < 2'd2 || ready_flag);
    result.loop_write    = r_lw;
    result.loop_addr     = r_la;
    result.key_on        = r_kon;
    result.dest_half     = r_half;
    result.loop_flag     = r_mle;
    result.pitch_write   = r_pw;
    result.pitch         = r_pw ? pitch_q : '0;
    result.play_clock    = r_zero_clk ? 32'd0 : {quotient[29:0], 2'b00};
  end

  `DBSC_ASSERT_IMP(a_fin_no_lw, r_fin, !r_lw, "finish with loop write")
  `DBSC_ASSERT_IMP(a_lw_addr, !r_lw && cmd.step == 1'b0 && r_fin, r_la == 16'h0000,
                   "loop address without write")
  `DBSC_ASSERT_NEXT(a_start_active, cmd.step && item.command == CMD_START, active,
                    "start did not activate")
endmodule
`default_nettype wire

// ===== sv/dbsc_control.sv =====
// ---------------------------------------------------------------------------
// dbsc_control
// sequences one item: accept, step, clock divide, present
// ---------------------------------------------------------------------------
`default_nettype none
`include "double_buffer_stream_control_unit_defines.svh"
module dbsc_control (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     load,
  output dbsc_pkg::dp_cmd_t        cmd,
  input  wire dbsc_pkg::dp_status_t status
);
  import dbsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_CLOCK, S_CWAIT, S_OUT
  } state_t;

  state_t state;

  assign in_stall  = (state != S_IDLE);
  assign load      = in_valid && (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.step      = (state == S_STEP);
  assign cmd.div_start = (state == S_CLOCK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (in_valid) state <= S_STEP;
        S_STEP:  state <= S_CLOCK;
        S_CLOCK: state <= S_CWAIT;
        S_CWAIT: if (!status.div_busy) state <= S_OUT;
        S_OUT:   if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `DBSC_ASSERT_IMP(a_one_side, out_valid, in_stall, "input open while result waits")
  `DBSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")
  `DBSC_ASSERT_IMP(a_step_once, cmd.step, !cmd.div_start, "step overlaps divide")
endmodule
`default_nettype wire

// ===== sv/double_buffer_stream_control_unit.sv =====
// ---------------------------------------------------------------------------
// double_buffer_stream_control_unit
// ping-pong buffer stream control for one adpcm voice
// ---------------------------------------------------------------------------
// One item at a time. An item is accepted, its stream state is updated,
// the play clock divide is started and waits on the bit-serial divider,
// and the result is handed over; no new item is taken until the result
// has been taken. The pitch comes from a reciprocal multiply that settles
// while the clock divides.
`default_nettype none
module double_buffer_stream_control_unit #(
  parameter int HALF_SIZE = 24576
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire dbsc_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output dbsc_pkg::out_item_t       out_item
);
  import dbsc_pkg::*;

  in_item_t   item;
  logic       load;
  dp_cmd_t    cmd;
  dp_status_t status;

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

  dbsc_control u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .load      (load),
    .cmd       (cmd),
    .status    (status)
  );

  dbsc_datapath #(.HALF_SIZE(HALF_SIZE)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (out_item)
  );
endmodule
`default_nettype wire

// ===== verif/double_buffer_stream_control_unit_tb.sv =====
// ---------------------------------------------------------------------------
// double_buffer_stream_control_unit_tb
// checks the stream control unit against a cycle-free model of the stream
// logic: directed streams, then random streams with bursty input and stalls
// ---------------------------------------------------------------------------
`default_nettype none
module double_buffer_stream_control_unit_tb;
  import dbsc_pkg::*;

  localparam int HALF_SIZE = 24576;
  localparam longint LEFT_MIN = -64'sd4294967296;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  int error_count = 0;
  int idle_cycles = 0;
  bit driving_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_buffer_stream_control_unit #(.HALF_SIZE(HALF_SIZE)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  class stream_scoreboard;
    bit active, stopped, started, playing, ready_flag, loop_moved;
    bit last_half, end_valid, buffer_parity;
    longint stop_point, bytes_left;
    logic [31:0] stream_rate, play_pos, sample_total;
    int buffers_seen;
    out_item_t pending[$];

    function new();
      clear_stream();
      active = 0; playing = 0; last_half = 0;
      stream_rate = 0; play_pos = 48; sample_total = 0;
    endfunction

    function void clear_stream();
      stopped = 0; started = 0; ready_flag = 0; loop_moved = 0;
      end_valid = 0; stop_point = 0; bytes_left = 0;
      buffers_seen = 0; buffer_parity = 0;
    endfunction

    function void consume();
      bytes_left -= HALF_SIZE;
      if (bytes_left < LEFT_MIN) bytes_left = LEFT_MIN;
    endfunction

    function logic [31:0] clock_now();
      logic [63:0] p;
      if (stream_rate == 0) return 0;
      p = 64'h1C00 * {32'd0, sample_total / 16};
      p = p / {32'd0, stream_rate};
      return p[31:0] * 4;
    endfunction

    function void note_input(input in_item_t it);
      out_item_t r;
      logic [31:0] len, rate, pos;
      logic [63:0] p;
      longint pp;
      bit alive, decided, second, first;
      r = '0;
      len = it.header_length;
      rate = it.header_rate;
      if (it.command == CMD_START) begin
        clear_stream();
        playing = 0; play_pos = 48; sample_total = 0;
        ready_flag = 1; active = 1;
      end else if (it.command == CMD_BUFFER && active && !stopped) begin
        if (buffers_seen == 0) begin
          if (it.header_magic != MAGIC_SWAP && it.header_magic != MAGIC_PLAIN) begin
            stopped = 1;
            r.bad_header = 1;
          end else begin
            if (it.header_magic == MAGIC_SWAP) begin
              rate = {rate[7:0], rate[15:8], rate[23:16], rate[31:24]};
              len = {len[7:0], len[15:8], len[23:16], len[31:24]};
            end
            stream_rate = rate;
            last_half = 0;
            bytes_left = longint'({32'd0, len}) + 48;
            if (HALF_SIZE >= bytes_left) begin
              stop_point = bytes_left - 16;
              end_valid = 1;
            end
            if (!end_valid) begin
              r.loop_write = 1;
              r.loop_addr = TRAP_ADDR;
            end
            r.key_on = 1;
            started = 1;
            consume();
            buffers_seen = 1;
            buffer_parity = 1;
          end
        end else begin
          second = buffer_parity;
          if (HALF_SIZE < bytes_left) r.loop_flag = 1;
          else begin
            stop_point = second ? bytes_left + 64'sh5FF0 : bytes_left - 16;
            end_valid = 1;
          end
          r.dest_half = second;
          if (buffers_seen == 1) begin
            if (!it.hold_paused) begin
              p = {20'd0, stream_rate, 12'd0} / 64'd48000;
              r.pitch_write = 1;
              r.pitch = p > 64'h3FFF ? PITCH_MAX : p[13:0];
            end
            play_pos = 48;
            playing = 1;
          end else begin
            r.loop_write = 1;
            r.loop_addr = second ? HALF_BASE : 16'h0;
          end
          ready_flag = 0;
          consume();
          if (buffers_seen < 2) buffers_seen++;
          buffer_parity = !buffer_parity;
        end
      end else if (it.command == CMD_TICK && active) begin
        alive = 1;
        if (playing) begin
          if (it.voice_addr > ADDR_MAX) pos = last_half ? 32'hC000 : 32'h6000;
          else begin
            pos = it.voice_addr;
            last_half = pos >= 32'h6000;
          end
          if (pos >= play_pos) sample_total += pos - play_pos;
          else sample_total += pos + 32'hC000 - play_pos;
          play_pos = pos;
        end
        if (stopped) alive = 0;
        else if (started) begin
          decided = 0;
          if (end_valid) begin
            pp = longint'({32'd0, play_pos});
            if ((pp & ~64'sd15) == stop_point) begin
              alive = 0;
              decided = 1;
            end else if ((pp < 64'sh6000 && stop_point < 64'sh6000) ||
                         (pp > 64'sh5FFF && stop_point > 64'sh5FFF)) begin
              if (!loop_moved && play_pos < stop_point[31:0]) begin
                r.loop_write = 1;
                r.loop_addr = stop_point[15:0];
                loop_moved = 1;
              end
              decided = 1;
            end
          end
          if (!decided) begin
            first = play_pos < 32'h6000;
            if (first == buffer_parity) begin
              ready_flag = 1;
              r.loop_write = 1;
              r.loop_addr = TRAP_ADDR;
            end
          end
        end
        if (!alive) begin
          playing = 0; active = 0;
          clear_stream();
          r.finished = 1;
          r.loop_write = 0;
          r.loop_addr = 0;
        end
      end
      r.data_request = active && !stopped && (buffers_seen < 2 || ready_flag);
      r.play_clock = (it.command == CMD_NOP) ? 32'd0 : clock_now();
      pending.push_back(r);
    endfunction

    task check_result(input out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected item", 32'd0, 32'd0);
        return;
      end
      w = pending.pop_front();
      if (got.finished !== w.finished)
        report_mismatch("finished", 32'(got.finished), 32'(w.finished));
      if (got.bad_header !== w.bad_header)
        report_mismatch("bad_header", 32'(got.bad_header), 32'(w.bad_header));
      if (got.data_request !== w.data_request)
        report_mismatch("data_request", 32'(got.data_request), 32'(w.data_request));
      if (got.loop_write !== w.loop_write)
        report_mismatch("loop_write", 32'(got.loop_write), 32'(w.loop_write));
      if (got.loop_addr !== w.loop_addr)
        report_mismatch("loop_addr", 32'(got.loop_addr), 32'(w.loop_addr));
      if (got.key_on !== w.key_on)
        report_mismatch("key_on", 32'(got.key_on), 32'(w.key_on));
      if (got.dest_half !== w.dest_half)
        report_mismatch("dest_half", 32'(got.dest_half), 32'(w.dest_half));
      if (got.loop_flag !== w.loop_flag)
        report_mismatch("loop_flag", 32'(got.loop_flag), 32'(w.loop_flag));
      if (got.pitch_write !== w.pitch_write)
        report_mismatch("pitch_write", 32'(got.pitch_write), 32'(w.pitch_write));
      if (got.pitch !== w.pitch) report_mismatch("pitch", 32'(got.pitch), 32'(w.pitch));
      if (got.play_clock !== w.play_clock)
        report_mismatch("play_clock", got.play_clock, w.play_clock);
    endtask
  endclass

  stream_scoreboard stream_sb = new();

  // burst and gap shaping for the sender
  int burst_left = 0;

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    stream_sb.note_input(it);
  endtask

  function automatic in_item_t make_item(input logic [1:0] cmd);
    in_item_t it;
    it.command = cmd;
    it.voice_addr = $urandom();
    it.header_magic = $urandom();
    it.header_length = $urandom();
    it.header_rate = $urandom();
    it.hold_paused = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic logic [31:0] rand_addr();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(32'h5FF0, 32'h6010);
      2: return $urandom_range(32'hBFF0, 32'hC010);
      default: return $urandom_range(0, 32'hBFFF);
    endcase
  endfunction

  // open a stream and deliver a header buffer with random content
  task automatic send_header(input logic [31:0] len, input logic [31:0] rate,
                             input bit swapped);
    in_item_t it;
    it = make_item(CMD_START);
    send_item(it);
    it = make_item(CMD_BUFFER);
    it.header_magic = swapped ? MAGIC_SWAP : MAGIC_PLAIN;
    it.header_length = swapped ? {len[7:0], len[15:8], len[23:16], len[31:24]} : len;
    it.header_rate = swapped ? {rate[7:0], rate[15:8], rate[23:16], rate[31:24]} : rate;
    send_item(it);
  endtask

  int sent = 0;

  task automatic random_stream();
    in_item_t it;
    logic [31:0] len, rate;
    int n;
    case ($urandom_range(0, 3))
      0: len = $urandom_range(0, 30000);
      1: len = $urandom_range(0, 200000);
      2: len = $urandom();
      default: len = $urandom_range(24000, 50000);
    endcase
    case ($urandom_range(0, 3))
      0: rate = $urandom();
      1: rate = 0;
      default: rate = $urandom_range(8000, 48000);
    endcase
    send_header(len, rate, 1'($urandom_range(0, 1)));
    sent += 2;
    n = $urandom_range(5, 40);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: it = make_item(CMD_BUFFER);
        5: it = make_item(CMD_START);
        6: it = make_item(CMD_NOP);
        default: begin
          it = make_item(CMD_TICK);
          it.voice_addr = rand_addr();
        end
      endcase
      send_item(it);
      sent++;
    end
  endtask

  task automatic directed_items();
    in_item_t it;
    it = make_item(CMD_TICK);
    send_item(it);
    it = make_item(CMD_BUFFER);
    send_item(it);
    it = make_item(CMD_NOP);
    send_item(it);
    // bad magic, then a buffer ignored and a tick that finishes
    it = make_item(CMD_START);
    send_item(it);
    it = make_item(CMD_BUFFER);
    it.header_magic = 32'h0;
    send_item(it);
    send_item(make_item(CMD_BUFFER));
    send_item(make_item(CMD_TICK));
    // short plain stream, big rate saturates pitch
    send_header(32'd100, 32'hFFFF_FFFF, 1'b0);
    it = make_item(CMD_BUFFER);
    it.hold_paused = 1'b0;
    send_item(it);
    it = make_item(CMD_TICK);
    it.voice_addr = 32'hFFFF_FFFF;
    send_item(it);
    it.voice_addr = 32'd128;
    send_item(it);
    it.voice_addr = 32'd0;
    send_item(it);
    // huge swapped stream with overrun, start while active
    send_header(32'hFFFF_FFFF, 32'd48000, 1'b1);
    it = make_item(CMD_BUFFER);
    it.hold_paused = 1'b1;
    send_item(it);
    send_item(make_item(CMD_BUFFER));
    it = make_item(CMD_TICK);
    it.voice_addr = 32'h6000;
    send_item(it);
    it.voice_addr = 32'hBFFF;
    send_item(it);
    send_header(32'd0, 32'd0, 1'b1);
    send_item(make_item(CMD_TICK));
  endtask

  // receiver stall pattern
  initial begin
    int mode;
    @(posedge clk);
    while (1) begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) stream_sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_items();
    while (sent < 1050) random_stream();
    in_valid <= 1'b0;
    driving_done = 1'b1;
  end

  initial begin
    wait (driving_done || idle_cycles >= WATCHDOG_LIMIT);
    while (driving_done && stream_sb.pending.size() != 0 && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
    end else begin
      repeat (200) @(posedge clk);
      if (error_count == 0 && stream_sb.pending.size() == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/dbsc_pkg.sv
sv/dbsc_divider.sv
sv/dbsc_datapath.sv
sv/dbsc_control.sv
sv/double_buffer_stream_control_unit.sv
verif/double_buffer_stream_control_unit_tb.sv
